/* hdl/bke_pkg.sv */
// ----------------------------------------------------------------------------
// Bezier keyframe expander package
// Shared types, fixed-point constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bke_pkg;

  localparam int FRAC      = 16;
  localparam int TIME_FRAC = 8;
  localparam int Y_OFFSET  = 4;
  localparam int HANDLE_DIV = 127;
  localparam int MAXS      = 64;

  // register indexes
  localparam logic [0:0] REG_SAMPLE_COUNT  = 1'b0;
  localparam logic [0:0] REG_CURVE_CHANNEL = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HANDLE,
    ST_TDIV,
    ST_MIX,
    ST_TIME,
    ST_VALUE,
    ST_OUT
  } bke_state_t;

  // commands from the sequencer to the shared multiply-add unit
  typedef struct packed {
    logic        start;
    logic [17:0] a;
    logic [17:0] b;
    logic [16:0] t;
  } bke_mix_cmd_t;

endpackage

/* hdl/bezier_keyframe_expander_unit.sv */
// A linear or first key offers its one result in the cycle after its transfer.
// A curved key first scales its four handle bytes, then per sample runs the t
// division, the blend steps on the shared blend unit and scaling in ST_TIME, ST_VALUE.
// One key at a time; the input reopens in the cycle after the last output transfer.
// Reset: synchronous; sample_count returns to 4, curve_channel to 0, and
// the previous key is cleared.
// ----------------------------------------------------------------------------
// Bezier keyframe expander
// Expands one keyframe into cubic Bezier samples with a shared blend unit.
// ----------------------------------------------------------------------------
module bezier_keyframe_expander_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] key_time,
  input  logic signed [31:0] key_value,
  input  logic [63:0] interp_row_a,
  input  logic [63:0] interp_row_b,
  input  logic        track_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] out_time,
  output logic signed [31:0] out_value,
  output logic        out_last
);

  bke_pkg::bke_state_t state, state_next;

  logic [6:0]  sample_count;
  logic [1:0]  curve_channel;
  logic [31:0] prev_time;
  logic signed [31:0] prev_value;
  logic        prev_valid;

  // key under work
  logic [31:0] cur_time, p_time;
  logic signed [31:0] cur_value, p_value;
  logic [7:0]  hb [4];      // ax ay bx by bytes
  logic [17:0] h  [4];      // handle coordinates
  logic [6:0]  n;
  logic [6:0]  idx;         // sample index i
  logic [16:0] t;

  // t divider: restoring, one quotient bit per cycle
  logic [23:0] div_num;
  logic [6:0]  div_den;
  logic [7:0]  rem;
  logic [4:0]  bitc;
  logic [1:0]  hsel;

  // handle scaling: byte * 2^16 / 127, rounded
  logic [7:0]  hbyte;
  logic [10:0] hm;
  logic [22:0] hq;
  logic [17:0] handle_q;

  // blend schedule
  logic [3:0]  step;
  logic [17:0] q [6];
  logic [17:0] mres;
  bke_pkg::bke_mix_cmd_t mcmd;
  logic [17:0] sx, sy;

  // final scaling
  logic signed [56:0] tprod;
  logic signed [57:0] vprod;

  logic        in_xfer, out_xfer;
  logic        linear;
  logic [7:0]  ax, ay, bx, by;
  logic [6:0]  n_eff;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    ax = interp_row_a[8*curve_channel +: 8];
    ay = interp_row_a[8*(curve_channel + 3'd4) +: 8];
    bx = interp_row_b[8*curve_channel +: 8];
    by = interp_row_b[8*(curve_channel + 3'd4) +: 8];
    linear = track_start || !prev_valid || (ax == ay && bx == by);
    if (sample_count == 7'd0) n_eff = 7'd1;
    else if (sample_count > 7'(bke_pkg::MAXS)) n_eff = 7'(bke_pkg::MAXS);
    else n_eff = sample_count;
  end

  // 2^16 = 516*127 + 4, so the handle is 516*b + (4*b + 63) / 127;
  // the small quotient comes from a reciprocal multiply by 2065 / 2^18
  always_comb begin
    hbyte    = hb[hsel];
    hm       = {1'b0, hbyte, 2'b00} + 11'd63;
    hq       = 23'(hm) * 23'd2065;
    handle_q = 18'({hbyte, 9'd0}) + 18'({hbyte, 2'b00}) + 18'(hq[22:18]);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= 7'd4;
      curve_channel <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bke_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg_data;
        bke_pkg::REG_CURVE_CHANNEL: curve_channel <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // blend operand selection for step k of de Casteljau
  always_comb begin
    mcmd = '0;
    mcmd.t = t;
    mcmd.start = (state == bke_pkg::ST_MIX);
    unique case (step)
      4'd0:  begin mcmd.a = '0;     mcmd.b = 18'(h[0]); end
      4'd1:  begin mcmd.a = '0;     mcmd.b = 18'(h[1]); end
      4'd2:  begin mcmd.a = 18'(h[0]); mcmd.b = 18'(h[2]); end
      4'd3:  begin mcmd.a = 18'(h[1]); mcmd.b = 18'(h[3]); end
      4'd4:  begin mcmd.a = 18'(h[2]); mcmd.b = 18'h10000; end
      4'd5:  begin mcmd.a = 18'(h[3]); mcmd.b = 18'h10000; end
      4'd6:  begin mcmd.a = q[0];  mcmd.b = q[2]; end
      4'd7:  begin mcmd.a = q[1];  mcmd.b = q[3]; end
      4'd8:  begin mcmd.a = q[2];  mcmd.b = q[4]; end
      4'd9:  begin mcmd.a = q[3];  mcmd.b = q[5]; end
      4'd10: begin mcmd.a = q[0];  mcmd.b = q[2]; end
      4'd11: begin mcmd.a = q[1];  mcmd.b = q[3]; end
      default: begin mcmd.a = '0; mcmd.b = '0; end
    endcase
  end

  bke_mix u_mix (.clk(clk), .cmd(mcmd), .res(mres));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bke_pkg::ST_IDLE:   if (in_xfer) state_next = linear ? bke_pkg::ST_OUT
                                                            : bke_pkg::ST_HANDLE;
      bke_pkg::ST_HANDLE: if (hsel == 2'd3) state_next = bke_pkg::ST_TDIV;
      bke_pkg::ST_TDIV:   if (bitc == 5'd23) state_next = bke_pkg::ST_MIX;
      bke_pkg::ST_MIX:    if (step == 4'd12) state_next = bke_pkg::ST_TIME;
      bke_pkg::ST_TIME:   state_next = bke_pkg::ST_VALUE;
      bke_pkg::ST_VALUE:  state_next = bke_pkg::ST_OUT;
      bke_pkg::ST_OUT:    if (out_xfer) state_next = out_last ? bke_pkg::ST_IDLE
                                                               : bke_pkg::ST_TDIV;
      default:            state_next = bke_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != bke_pkg::ST_IDLE);
    out_valid = (state == bke_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bke_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      prev_value <= '0;
      prev_valid <= 1'b0;
    end else if (in_xfer) begin
      prev_time  <= key_time;
      prev_value <= key_value;
      prev_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bke_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cur_time <= key_time; cur_value <= key_value;
          p_time <= prev_time;  p_value <= prev_value;
          hb[0] <= ax; hb[1] <= ay; hb[2] <= bx; hb[3] <= by;
          n <= n_eff; idx <= '0; hsel <= '0; bitc <= '0; rem <= '0;
          out_time  <= {key_time, 8'd0};
          out_value <= key_value;
          out_last  <= 1'b1;
        end
      end
      bke_pkg::ST_HANDLE: begin
        // one handle coordinate per cycle, then set up the first t division
        h[hsel] <= handle_q;
        hsel <= hsel + 2'd1;
        if (hsel == 2'd3) begin
          div_num <= 24'({idx + 7'd1, 16'd0}) + 24'(n >> 1);
          div_den <= n;
          bitc <= '0; rem <= '0;
        end
      end
      bke_pkg::ST_TDIV: begin
        // restoring division step: 24-bit dividend, 7-bit divisor
        logic [8:0] trial;
        logic [23:0] qn;
        trial = {rem, div_num[23]} - {2'b0, div_den};
        qn = {div_num[22:0], !trial[8]};
        rem <= trial[8] ? {rem[6:0], div_num[23]} : trial[7:0];
        div_num <= qn;
        bitc <= bitc + 5'd1;
        if (bitc == 5'd23) begin
          t <= qn[16:0];
          step <= '0;
        end
      end
      bke_pkg::ST_MIX: begin
        step <= step + 4'd1;
        // result of the previous step arrives now
        if (step != 4'd0) begin
          if (step <= 4'd6) q[3'(step - 4'd1)] <= mres;
          else if (step <= 4'd8) q[3'(step - 4'd7)] <= mres;  // r0x,r0y over q0,q1
          else if (step <= 4'd10) q[3'(step - 4'd7)] <= mres; // r1x,r1y over q2,q3
          else if (step == 4'd11) sx <= mres;
          else sy <= mres;
        end
      end
      bke_pkg::ST_TIME: begin
        tprod <= 57'(signed'({1'b0, cur_time}) - signed'({1'b0, p_time}))
               * 57'(signed'({1'b0, sx}));
        vprod <= 58'(signed'({cur_value[31], cur_value}) - signed'({p_value[31], p_value}))
               * 58'(signed'({1'b0, sy}));
      end
      bke_pkg::ST_VALUE: begin
        logic signed [57:0] tv, vv;
        tv = (58'(signed'({1'b0, p_time, 16'd0})) + 58'(tprod) + 58'sd128) >>> 8;
        vv = 58'(p_value) + ((vprod + 58'sd32768) >>> 16);
        if (tv < 0) out_time <= '0;
        else if (tv > 58'sh0FF_FFFF_FFFF) out_time <= '1;
        else out_time <= tv[39:0];
        if (vv > 58'sh7FFF_FFFF) out_value <= 32'sh7FFF_FFFF;
        else if (vv < -58'sh8000_0000) out_value <= 32'sh8000_0000;
        else out_value <= vv[31:0];
        out_last <= (idx + 7'd1 == n);
      end
      bke_pkg::ST_OUT: begin
        if (out_xfer && !out_last) begin
          idx <= idx + 7'd1;
          div_num <= 24'({idx + 7'd2, 16'd0}) + 24'(n >> 1);
          bitc <= '0; rem <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/bke_mix.sv */
// ----------------------------------------------------------------------------
// Shared blend unit
// One registered lerp: (a*(1-t) + b*t + half) >> FRAC on unsigned values.
// ----------------------------------------------------------------------------
module bke_mix (
  input  logic                 clk,
  input  bke_pkg::bke_mix_cmd_t cmd,
  output logic [17:0]          res
);

  logic [36:0] acc;

  // two products, one sum; result registered
  always_comb begin
    acc = 37'(cmd.a) * 37'(18'h10000 - 18'(cmd.t)) + 37'(cmd.b) * 37'(cmd.t)
        + 37'(1 << (bke_pkg::FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res <= acc[bke_pkg::FRAC +: 18];
    end
  end

endmodule

/* hdl/bke_checker.sv */
// ----------------------------------------------------------------------------
// Bezier keyframe expander port checker
// Watches the top level ports for sequencing errors.
// ----------------------------------------------------------------------------
module bke_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_last
);

  // never accepting input while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");

  // after a last transfer the block is idle again
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_last) |=> !out_valid && !in_stall)
    else $error("not idle after last");

  // an accepted input closes the input side
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("input not closed");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind bezier_keyframe_expander_unit bke_checker u_bke_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_last(out_last)
);
